/* rtl/abs_slip_brake_modulator_core_assert.svh */
// Assertion helpers for the ABS slip modulator.
// Both expect clk and rst_n in the scope where they are used.
`ifndef ABS_SLIP_BRAKE_MODULATOR_CORE_ASSERT_SVH
`define ABS_SLIP_BRAKE_MODULATOR_CORE_ASSERT_SVH

// same-cycle implication
`define ABSM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("absm assertion failed");

// next-cycle implication
`define ABSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("absm assertion failed");

`endif

/* rtl/absm_pkg.sv */
`timescale 1ns / 1ps

package absm_pkg;

  localparam int WHEELS    = 4;
  localparam int IN_WHEELS = 4;
  localparam int LANES     = (WHEELS < IN_WHEELS) ? WHEELS : IN_WHEELS;

  localparam int SPD_W   = 16;
  localparam int PEDAL_W = 13;
  localparam int THR_W   = 15;
  localparam int MAXP_W  = 8;
  localparam int OUT_W   = 15;
  localparam int SLIP_W  = 16;
  localparam int PM_W    = PEDAL_W + MAXP_W;
  // pedal * max_pressure * 5 needs three bits over the product
  localparam int BASE_W  = PM_W + 3;

  // one quotient bit per divider step: Q14 plus one bit for the value 1.0
  localparam int DIV_STEPS = 15;
  localparam int ST_MOD    = DIV_STEPS + 1;
  localparam int ST_TRQ    = DIV_STEPS + 2;
  localparam int NS        = DIV_STEPS + 3;

  localparam logic [14:0]      Q14_ONE   = 15'd16384;
  localparam logic [SPD_W-1:0] MIN_SPEED = 16'd256;
  localparam logic [14:0]      PRESS_K   = 15'd19661;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLIP_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PRES = 2'd2;

  typedef struct packed {
    logic load;
    logic valid;
    logic enable;
    logic run;
  } merge_ctl_t;

  function automatic logic [OUT_W-1:0] sat_out(input logic [OUT_W:0] x);
    return x[OUT_W] ? {OUT_W{1'b1}} : x[OUT_W-1:0];
  endfunction

endpackage

/* rtl/absm_lane.sv */
`timescale 1ns / 1ps

module absm_lane (
  input  logic                           clk,
  input  logic [absm_pkg::NS-1:0]        adv,
  input  logic [absm_pkg::SPD_W-1:0]     vehicle_speed,
  input  logic [absm_pkg::SPD_W-1:0]     wheel_speed,
  input  logic [absm_pkg::SPD_W-1:0]     v_div [absm_pkg::DIV_STEPS],
  input  logic [absm_pkg::THR_W-1:0]     slip_threshold,
  input  logic [absm_pkg::BASE_W-1:0]    base,
  output logic [absm_pkg::OUT_W-1:0]     torque,
  output logic [absm_pkg::SLIP_W-1:0]    slip,
  output logic [14:0]                    modulation
);

  logic [16:0] rem_r [absm_pkg::DIV_STEPS];
  logic [14:0] q_r   [absm_pkg::DIV_STEPS+1];
  logic        neg_r [absm_pkg::DIV_STEPS+1];
  logic        big_r [absm_pkg::DIV_STEPS+1];

  logic [15:0] diff;
  logic        big;

  always_comb begin
    diff = (vehicle_speed >= wheel_speed) ? (vehicle_speed - wheel_speed)
                                          : (wheel_speed - vehicle_speed);
    // quotient at or above 2.0 saturates anyway, skip dividing
    big  = {1'b0, diff} >= {vehicle_speed, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem_r[0] <= {1'b0, diff};
      q_r[0]   <= '0;
      neg_r[0] <= wheel_speed > vehicle_speed;
      big_r[0] <= big;
    end
  end

  // restoring divider, one quotient bit per stage
  genvar k;
  for (k = 0; k < absm_pkg::DIV_STEPS; k++) begin : g_div
    logic ge;
    assign ge = rem_r[k] >= {1'b0, v_div[k]};

    always_ff @(posedge clk) begin
      if (adv[k+1]) begin
        q_r[k+1]   <= {q_r[k][13:0], ge};
        neg_r[k+1] <= neg_r[k];
        big_r[k+1] <= big_r[k];
      end
    end

    if (k < absm_pkg::DIV_STEPS - 1) begin : g_rem
      logic [16:0] r2;
      assign r2 = ge ? (rem_r[k] - {1'b0, v_div[k]}) : rem_r[k];
      always_ff @(posedge clk) begin
        if (adv[k+1]) rem_r[k+1] <= {r2[15:0], 1'b0};
      end
    end
  end

  logic [14:0] mag;
  logic [15:0] slip_c;
  logic        over;
  logic [15:0] excess;
  logic [16:0] cut;
  logic [14:0] cut_c;
  logic [14:0] mod_c;

  always_comb begin
    mag = (big_r[absm_pkg::DIV_STEPS] || q_r[absm_pkg::DIV_STEPS] > absm_pkg::Q14_ONE)
          ? absm_pkg::Q14_ONE : q_r[absm_pkg::DIV_STEPS];
    slip_c = neg_r[absm_pkg::DIV_STEPS] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
    over   = $signed(slip_c) > $signed({1'b0, slip_threshold});
    excess = slip_c - {1'b0, slip_threshold};
    cut    = {2'b00, excess[14:0]} + {excess[14:0], 2'b00};
    cut_c  = (cut > {2'b00, absm_pkg::Q14_ONE}) ? absm_pkg::Q14_ONE : cut[14:0];
    mod_c  = over ? (absm_pkg::Q14_ONE - cut_c) : absm_pkg::Q14_ONE;
  end

  logic [15:0] slip_m_r;
  logic [14:0] mod_m_r;

  always_ff @(posedge clk) begin
    if (adv[absm_pkg::ST_MOD]) begin
      slip_m_r <= slip_c;
      mod_m_r  <= mod_c;
    end
  end

  // modulation never exceeds 1.0, so the product fits BASE_W + 14 bits
  logic [absm_pkg::BASE_W+13:0] prod;
  assign prod = (absm_pkg::BASE_W+14)'(base) * (absm_pkg::BASE_W+14)'(mod_m_r);

  logic [absm_pkg::OUT_W-1:0]  torque_r;
  logic [absm_pkg::SLIP_W-1:0] slip_r;
  logic [14:0]                 mod_r;

  always_ff @(posedge clk) begin
    if (adv[absm_pkg::ST_TRQ]) begin
      torque_r <= absm_pkg::sat_out(prod[absm_pkg::BASE_W+13:22]);
      slip_r   <= slip_m_r;
      mod_r    <= mod_m_r;
    end
  end

  assign torque     = torque_r;
  assign slip       = slip_r;
  assign modulation = mod_r;

endmodule

/* rtl/absm_merge.sv */
`timescale 1ns / 1ps

module absm_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  absm_pkg::merge_ctl_t        ctl,
  input  logic [absm_pkg::OUT_W-1:0]  torque_in [absm_pkg::IN_WHEELS],
  input  logic [absm_pkg::OUT_W-1:0]  pressure_in,
  input  logic [absm_pkg::SLIP_W-1:0] slip_in,
  input  logic [14:0]                 mod_in,
  output logic                        out_valid,
  output logic [absm_pkg::OUT_W-1:0]  torque [absm_pkg::IN_WHEELS],
  output logic [absm_pkg::OUT_W-1:0]  pressure,
  output logic                        active,
  output logic [absm_pkg::SLIP_W-1:0] slip,
  output logic [14:0]                 modulation
);

  // held state doubles as the output register: it only changes when the
  // slot is free, so it always matches the request on offer
  logic                        out_valid_r;
  logic [absm_pkg::OUT_W-1:0]  torque_r [absm_pkg::IN_WHEELS];
  logic [absm_pkg::OUT_W-1:0]  pressure_r;
  logic                        active_r;
  logic [absm_pkg::SLIP_W-1:0] slip_r;
  logic [14:0]                 mod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < absm_pkg::IN_WHEELS; i++) torque_r[i] <= '0;
      pressure_r  <= '0;
      active_r    <= 1'b0;
      slip_r      <= '0;
      mod_r       <= '0;
    end else if (ctl.load) begin
      out_valid_r <= ctl.valid;
      if (ctl.valid && ctl.enable) begin
        if (ctl.run) begin
          for (int i = 0; i < absm_pkg::IN_WHEELS; i++) torque_r[i] <= torque_in[i];
          pressure_r <= pressure_in;
          slip_r     <= slip_in;
          mod_r      <= mod_in;
          active_r   <= 1'b1;
        end else begin
          active_r   <= 1'b0;
        end
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign torque     = torque_r;
  assign pressure   = pressure_r;
  assign active     = active_r;
  assign slip       = slip_r;
  assign modulation = mod_r;

endmodule

/* rtl/abs_slip_brake_modulator_core.sv */
`timescale 1ns / 1ps
// Throughput: one request per cycle unless the output stalls; each wheel lane runs
// a 15-stage pipelined restoring divider for slip, followed by a modulation stage
// and a torque multiply.
// Stages fill independently, so bubbles close up while the output waits.
// Reset (rst_n low, synchronous): pipeline emptied, held outputs zero,
// enable = 1, slip threshold = 4096, max pressure = 100.

module abs_slip_brake_modulator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // vehicle_speed[15:0], wheel_fl[31:16], wheel_fr[47:32], wheel_rl[63:48],
  // wheel_rr[79:64], pedal[92:80], zero pad[95:93]
  input  logic [95:0]                        in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // torque_fl[14:0], torque_fr[29:15], torque_rl[44:30], torque_rr[59:45],
  // pressure[74:60], slip_front_left[90:75], modulation_front_left[105:91],
  // zero pad[111:106]
  output logic [111:0]                       out_tdata,
  // active[0]
  output logic [0:0]                         out_tuser,
  input  logic                               cfg_we,
  input  logic [absm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [absm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  `include "abs_slip_brake_modulator_core_assert.svh"

  localparam int NS  = absm_pkg::NS;
  localparam int SW  = absm_pkg::SPD_W;

  // configuration
  logic                        enable_r;
  logic [absm_pkg::THR_W-1:0]  thr_r;
  logic [absm_pkg::MAXP_W-1:0] maxp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      thr_r    <= 15'd4096;
      maxp_r   <= 8'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        absm_pkg::REG_ENABLE:   enable_r <= cfg_wdata[0];
        absm_pkg::REG_SLIP_THR: thr_r    <= cfg_wdata;
        absm_pkg::REG_MAX_PRES: maxp_r   <= cfg_wdata[absm_pkg::MAXP_W-1:0];
        default: ;
      endcase
    end
  end

  // input unpacking
  logic [SW-1:0]                vehicle_speed;
  logic [SW-1:0]                wheel_in [absm_pkg::IN_WHEELS];
  logic [absm_pkg::PEDAL_W-1:0] pedal;

  always_comb begin
    vehicle_speed = in_tdata[SW-1:0];
    for (int i = 0; i < absm_pkg::IN_WHEELS; i++) wheel_in[i] = in_tdata[SW*(i+1) +: SW];
    pedal = in_tdata[SW*(absm_pkg::IN_WHEELS+1) +: absm_pkg::PEDAL_W];
  end

  // stage handshake: a stage loads when it is empty or its successor moves
  logic          out_valid;
  logic [NS-1:0] valid_r;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = !out_valid || out_tready;
    for (int s = NS - 1; s >= 0; s--) rdy[s] = !valid_r[s] || rdy[s+1];
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rdy[0]) valid_r[0] <= in_tvalid;
      for (int s = 1; s < NS; s++) begin
        if (rdy[s]) valid_r[s] <= valid_r[s-1];
      end
    end
  end

  // shared side pipeline: divisor, run flag, torque base, pressure
  logic [SW-1:0]               v_r     [absm_pkg::DIV_STEPS];
  logic                        run_r   [NS];
  logic [absm_pkg::PM_W-1:0]   pm_r;
  logic [absm_pkg::BASE_W-1:0] base_r  [1:absm_pkg::ST_MOD];
  logic [absm_pkg::OUT_W-1:0]  press_r [1:NS-1];

  logic [absm_pkg::PM_W+14:0]  press_prod;
  assign press_prod = (absm_pkg::PM_W+15)'(pm_r) * (absm_pkg::PM_W+15)'(absm_pkg::PRESS_K);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      v_r[0]   <= vehicle_speed;
      run_r[0] <= vehicle_speed >= absm_pkg::MIN_SPEED;
      pm_r     <= absm_pkg::PM_W'(pedal) * absm_pkg::PM_W'(maxp_r);
    end
    if (rdy[1]) begin
      base_r[1]  <= {3'b000, pm_r} + {1'b0, pm_r, 2'b00};
      press_r[1] <= absm_pkg::sat_out(press_prod[absm_pkg::PM_W+14:20]);
    end
    for (int s = 1; s < NS; s++) begin
      if (rdy[s]) begin
        run_r[s] <= run_r[s-1];
        if (s < absm_pkg::DIV_STEPS) v_r[s] <= v_r[s-1];
        if (s > 1 && s <= absm_pkg::ST_MOD) base_r[s] <= base_r[s-1];
        if (s > 1) press_r[s] <= press_r[s-1];
      end
    end
  end

  // wheel lanes
  logic [absm_pkg::OUT_W-1:0]  lane_torque [absm_pkg::IN_WHEELS];
  logic [absm_pkg::SLIP_W-1:0] lane_slip   [absm_pkg::IN_WHEELS];
  logic [14:0]                 lane_mod    [absm_pkg::IN_WHEELS];

  genvar i;
  for (i = 0; i < absm_pkg::IN_WHEELS; i++) begin : g_lane
    if (i < absm_pkg::LANES) begin : g_on
      absm_lane u_lane (
        .clk            (clk),
        .adv            (rdy[NS-1:0]),
        .vehicle_speed  (vehicle_speed),
        .wheel_speed    (wheel_in[i]),
        .v_div          (v_r),
        .slip_threshold (thr_r),
        .base           (base_r[absm_pkg::ST_MOD]),
        .torque         (lane_torque[i]),
        .slip           (lane_slip[i]),
        .modulation     (lane_mod[i])
      );
    end else begin : g_off
      assign lane_torque[i] = '0;
      assign lane_slip[i]   = '0;
      assign lane_mod[i]    = '0;
    end
  end

  // merge and hold
  absm_pkg::merge_ctl_t        mctl;
  logic [absm_pkg::OUT_W-1:0]  held_torque [absm_pkg::IN_WHEELS];
  logic [absm_pkg::OUT_W-1:0]  held_pressure;
  logic                        held_active;
  logic [absm_pkg::SLIP_W-1:0] held_slip;
  logic [14:0]                 held_mod;

  always_comb begin
    mctl.load   = rdy[NS];
    mctl.valid  = valid_r[NS-1];
    mctl.enable = enable_r;
    mctl.run    = run_r[NS-1];
  end

  absm_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (mctl),
    .torque_in   (lane_torque),
    .pressure_in (press_r[NS-1]),
    .slip_in     (lane_slip[0]),
    .mod_in      (lane_mod[0]),
    .out_valid   (out_valid),
    .torque      (held_torque),
    .pressure    (held_pressure),
    .active      (held_active),
    .slip        (held_slip),
    .modulation  (held_mod)
  );

  assign out_tvalid = out_valid;
  assign out_tuser  = held_active;
  assign out_tdata  = {6'd0, held_mod, held_slip, held_pressure,
                       held_torque[3], held_torque[2], held_torque[1], held_torque[0]};

  // an empty output slot frees every stage
  `ABSM_ASSERT_IMPL(a_ready_when_empty, !out_tvalid, in_tready)
  // disabled requests leave every held output alone
  `ABSM_ASSERT_NEXT(a_disabled_holds, mctl.load && mctl.valid && !enable_r,
                    $stable(out_tdata) && $stable(out_tuser))
  // slow vehicle clears active but keeps torques
  `ABSM_ASSERT_NEXT(a_slow_clears, mctl.load && mctl.valid && enable_r && !mctl.run,
                    !out_tuser[0] && $stable(out_tdata))
  // running request sets active
  `ABSM_ASSERT_NEXT(a_run_sets, mctl.load && mctl.valid && enable_r && mctl.run,
                    out_tuser[0])

endmodule

/* sim/tb_abs_slip_brake_modulator_core.sv */
`timescale 1ns / 1ps

module tb_abs_slip_brake_modulator_core;

  localparam int CLK_HALF   = 10;
  localparam int STALL_MAX  = 5000;  // cycles with no accepted transfer
  localparam int SETTLE     = 40;    // longer than the pipeline latency
  localparam int Q14        = 16384;
  localparam int SLOW_SPEED = 256;
  localparam longint unsigned PRESS_GAIN = 19661;

  typedef struct packed {
    logic [12:0]      pedal;
    logic [3:0][15:0] wheel;   // fl, fr, rl, rr at index 0..3
    logic [15:0]      speed;
  } brake_req_t;

  typedef struct packed {
    logic [3:0][14:0] torque;
    logic [14:0]      pressure;
    logic             active;
    logic [15:0]      slip;
    logic [14:0]      modulation;
  } brake_result_t;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_we     = 1'b0;
  logic [absm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [absm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  abs_slip_brake_modulator_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // modulator model: settings and held outputs
  logic             mod_enable   = 1'b1;
  logic [14:0]      mod_slip_thr = 15'd4096;
  logic [7:0]       mod_max_pres = 8'd100;
  logic [3:0][14:0] held_torque  = '0;
  logic [14:0]      held_press   = '0;
  logic             held_active  = 1'b0;
  logic [15:0]      held_slip    = '0;
  logic [14:0]      held_mod     = '0;

  brake_result_t expected_brake_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_reg_writes = 0;
  int n_errors = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [14:0] sat15(input longint unsigned x);
    return (x > 32767) ? 15'h7FFF : x[14:0];
  endfunction

  task automatic predict_brake(input brake_req_t r);
    brake_result_t res;
    longint unsigned pm, diff, q, mm;
    int s, thr, cut, m;
    logic [15:0] w;
    if (mod_enable) begin
      if (r.speed < SLOW_SPEED) begin
        held_active = 1'b0;
      end else begin
        pm = r.pedal;
        pm = pm * mod_max_pres;
        thr = mod_slip_thr;
        for (int i = 0; i < 4; i++) begin
          w = r.wheel[i];
          diff = (r.speed >= w) ? r.speed - w : w - r.speed;
          q = (diff << 14) / r.speed;
          if (q > Q14) q = Q14;
          s = (r.speed >= w) ? int'(q) : -int'(q);
          if (s <= thr) begin
            m = Q14;
          end else begin
            cut = (s - thr) * 5;
            if (cut > Q14) cut = Q14;
            m = Q14 - cut;
          end
          mm = m;
          held_torque[i] = sat15((pm * 5 * mm) >> 22);
          if (i == 0) begin
            held_slip = s[15:0];
            held_mod = m[14:0];
          end
        end
        held_press = sat15((pm * PRESS_GAIN) >> 20);
        held_active = 1'b1;
      end
    end
    res.torque = held_torque;
    res.pressure = held_press;
    res.active = held_active;
    res.slip = held_slip;
    res.modulation = held_mod;
    expected_brake_q.push_back(res);
  endtask

  // call at a rising edge; returns at the edge the request is taken
  task automatic send_request(input brake_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, r.pedal, r.wheel[3], r.wheel[2], r.wheel[1], r.wheel[0], r.speed};
    do @(posedge clk); while (!in_tready);
    n_requests++;
    predict_brake(r);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (expected_brake_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // writes all three registers; only while nothing is in flight
  task automatic apply_settings(input logic en, input logic [14:0] thr, input logic [7:0] maxp);
    cfg_we <= 1'b1;
    cfg_index <= absm_pkg::REG_ENABLE;
    cfg_wdata <= {14'd0, en};
    @(posedge clk);
    cfg_index <= absm_pkg::REG_SLIP_THR;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_index <= absm_pkg::REG_MAX_PRES;
    cfg_wdata <= {7'd0, maxp};
    @(posedge clk);
    cfg_we <= 1'b0;
    mod_enable = en;
    mod_slip_thr = thr;
    mod_max_pres = maxp;
    n_reg_writes += 3;
  endtask

  function automatic brake_req_t mk_req(input logic [15:0] v, input logic [15:0] fl,
                                        input logic [15:0] fr, input logic [15:0] rl,
                                        input logic [15:0] rr, input logic [12:0] pedal);
    brake_req_t r;
    r.speed = v;
    r.wheel[0] = fl;
    r.wheel[1] = fr;
    r.wheel[2] = rl;
    r.wheel[3] = rr;
    r.pedal = pedal;
    return r;
  endfunction

  // wheel speed biased around the vehicle speed so slip lands near the threshold
  function automatic logic [15:0] rand_wheel(input int v);
    int w;
    case ($urandom_range(4))
      0: w = $urandom_range(65535);
      1: w = v - int'($urandom_range(v / 2));
      2: w = v - int'($urandom_range(v));
      3: w = v + int'($urandom_range(v / 4));
      default: w = v;
    endcase
    if (w > 65535) w = 65535;
    if (w < 0) w = 0;
    return w[15:0];
  endfunction

  function automatic brake_req_t rand_request();
    brake_req_t r;
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) r.speed = 16'($urandom_range(255));
    else if (sel < 20) r.speed = 16'($urandom_range(65535));
    else r.speed = 16'($urandom_range(256, 12000));
    for (int i = 0; i < 4; i++) r.wheel[i] = rand_wheel(r.speed);
    r.pedal = 13'(($urandom_range(99) < 80) ? $urandom_range(4096) : $urandom_range(8191));
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  brake_result_t got_r, want_r;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      for (int i = 0; i < 4; i++) got_r.torque[i] = out_tdata[15*i +: 15];
      got_r.pressure = out_tdata[60 +: 15];
      got_r.slip = out_tdata[75 +: 16];
      got_r.modulation = out_tdata[91 +: 15];
      got_r.active = out_tuser[0];
      if (expected_brake_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing pending, expected none actual %h", $time, out_tdata);
      end else begin
        want_r = expected_brake_q.pop_front();
        check_field("torque_fl", want_r.torque[0], got_r.torque[0]);
        check_field("torque_fr", want_r.torque[1], got_r.torque[1]);
        check_field("torque_rl", want_r.torque[2], got_r.torque[2]);
        check_field("torque_rr", want_r.torque[3], got_r.torque[3]);
        check_field("pressure", want_r.pressure, got_r.pressure);
        check_field("active", want_r.active, got_r.active);
        check_field("slip_fl", $signed(want_r.slip), $signed(got_r.slip));
        check_field("modulation_fl", want_r.modulation, got_r.modulation);
      end
    end
  end

  // downstream backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_MAX) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_MAX);
    $display("Regression FAIL");
    $finish;
  end

  task automatic test_reset_state();
    // default settings straight out of reset
    send_request(mk_req(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 13'd0));
    send_request(mk_req(16'd255, 16'd0, 16'd65535, 16'd255, 16'd100, 13'd4096));
    send_request(mk_req(16'd256, 16'd256, 16'd256, 16'd256, 16'd256, 13'd4096));
    send_request(mk_req(16'd256, 16'd0, 16'd192, 16'd180, 16'd65535, 13'd4096));
    send_request(mk_req(16'd1000, 16'd749, 16'd750, 16'd751, 16'd1200, 13'd2048));
    send_request(mk_req(16'd65535, 16'd65535, 16'd0, 16'd32768, 16'd49151, 13'd0));
    wait_for_results();
  endtask

  task automatic test_field_extremes();
    // full-scale pedal and max pressure saturate torque and pressure; then zero max pressure
    apply_settings(1'b1, 15'd0, 8'd255);
    send_request(mk_req(16'd65535, 16'd65535, 16'd65534, 16'd0, 16'd65535, 13'd8191));
    send_request(mk_req(16'd256, 16'd257, 16'd300, 16'd65535, 16'd256, 13'd4096));
    send_request(mk_req(16'd4000, 16'd3990, 16'd4000, 16'd0, 16'd8000, 13'd1));
    wait_for_results();
    apply_settings(1'b1, 15'd16384, 8'd0);
    send_request(mk_req(16'd2560, 16'd0, 16'd1280, 16'd2560, 16'd65535, 13'd8191));
    send_request(mk_req(16'd300, 16'd0, 16'd0, 16'd0, 16'd0, 13'd4096));
    wait_for_results();
  endtask

  task automatic test_threshold_above_one();
    // no slip can pass a threshold above unity
    apply_settings(1'b1, 15'h7FFF, 8'd200);
    send_request(mk_req(16'd512, 16'd0, 16'd0, 16'd65535, 16'd1, 13'd4096));
    send_request(mk_req(16'd20000, 16'd0, 16'd10000, 16'd19999, 16'd0, 13'd3000));
    wait_for_results();
  endtask

  task automatic test_disable_hold();
    apply_settings(1'b1, 15'd4096, 8'd100);
    send_request(mk_req(16'd2000, 16'd1200, 16'd1900, 16'd2000, 16'd800, 13'd3000));
    wait_for_results();
    apply_settings(1'b0, 15'd4096, 8'd100);
    send_request(mk_req(16'd5000, 16'd0, 16'd0, 16'd0, 16'd0, 13'd4096));
    send_request(mk_req(16'd10, 16'd0, 16'd0, 16'd0, 16'd0, 13'd4096));
    wait_for_results();
    // slow vehicle after re-enable: active drops, outputs hold
    apply_settings(1'b1, 15'd4096, 8'd100);
    send_request(mk_req(16'd100, 16'd0, 16'd500, 16'd0, 16'd0, 13'd4096));
    send_request(mk_req(16'd3000, 16'd2000, 16'd2500, 16'd3100, 16'd2900, 13'd2500));
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    logic en;
    logic [14:0] thr;
    logic [7:0] maxp;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int seg = 0; seg < 2; seg++) begin
      case ($urandom_range(4))
        0: thr = 15'd0;
        1: thr = 15'd16384;
        2: thr = 15'h7FFF;
        default: thr = 15'($urandom_range(16384));
      endcase
      case ($urandom_range(3))
        0: maxp = 8'd0;
        1: maxp = 8'd255;
        default: maxp = 8'($urandom_range(255));
      endcase
      en = ($urandom_range(9) != 0);
      apply_settings(en, thr, maxp);
      for (int k = 0; k < count / 2; k++) send_request(rand_request());
      wait_for_results();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_field_extremes();
    test_threshold_above_one();
    test_disable_hold();

    test_random_traffic(0, 0, 176);
    test_random_traffic(53, 0, 176);
    test_random_traffic(0, 53, 176);
    test_random_traffic(33, 33, 176);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_for_results();
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d wheel-speed requests, checked %0d results, %0d register writes",
             n_requests, n_results, n_reg_writes);
    $display("Covered saturation, slow vehicle hold, disable freeze and four flow-control mixes");
    if (n_errors == 0 && expected_brake_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, expected_brake_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
